### design/f5e_pkg.sv
// ----------------------------------------------------------------------------
// f5e_pkg
// Shared types, constants and helpers for the five-character float encoder.
// ----------------------------------------------------------------------------
package f5e_pkg;

  // Register stages from the input register to the result register.
  localparam int          PipeStages = 7;

  // Clamp limits as magnitude bit patterns (sign bit removed).
  localparam logic [62:0] BigBits   = 63'h45C027E72F1F1281;
  localparam logic [62:0] SmallBits = 63'h3A1FB0F6BE506019;

  localparam logic [10:0] ExpBias   = 11'd1023;
  // Biased exponent field minus this gives e + 129.
  localparam logic [10:0] ExpShift  = 11'd894;

  localparam logic [7:0]  Base1Wide = 8'd90;
  localparam logic [7:0]  GroupTwo  = 8'd180;
  localparam logic [23:0] FracOne   = 24'h800000;

  localparam int          Base3     = 729000;
  localparam int          Base3Max  = 11;
  localparam logic [19:0] Recip2    = 20'd530243;  // ceil(2^32 / 8100)
  localparam logic [12:0] Recip1    = 13'd5826;    // ceil(2^19 / 90)
  localparam logic [12:0] Base2     = 13'd8100;
  localparam logic [12:0] Base1     = 13'd90;

  localparam logic [6:0]  GroupStep = 7'd12;
  localparam logic [6:0]  NegOffset = 7'd40;
  localparam logic [6:0]  ZeroMark  = 7'd80;
  localparam logic [6:0]  CharBase  = 7'd33;
  localparam logic [6:0]  SkipLow   = 7'd94;
  localparam logic [6:0]  SkipHigh  = 7'd123;

  typedef struct packed {
    logic        zero;
    logic        neg;
    logic [1:0]  grp;
    logic [6:0]  dg3;
    logic [23:0] frac;
  } unpack_t;

  typedef struct packed {
    logic        zero;
    logic        neg;
    logic [1:0]  grp;
    logic [6:0]  dg3;
    logic [3:0]  q4;
    logic [6:0]  dg2;
    logic [6:0]  dg1;
    logic [12:0] r2;
  } digits_t;

  typedef struct packed {
    logic [6:0] c0;
    logic [6:0] c1;
    logic [6:0] c2;
    logic [6:0] c3;
    logic [6:0] c4;
  } chars_t;

  // Digit to printable character, stepping over the two excluded codes.
  function automatic logic [6:0] to_char(input logic [6:0] d);
    logic [6:0] c;
    c = d + CharBase;
    if (c >= SkipLow) c = c + 7'd1;
    if (c >= SkipHigh) c = c + 7'd1;
    return c;
  endfunction

endpackage

### design/f5e_unpack.sv
// ----------------------------------------------------------------------------
// f5e_unpack
// Clamps the magnitude and splits it into exponent group, exponent remainder
// and a 24-bit fraction.
// ----------------------------------------------------------------------------
module f5e_unpack (
  input  logic [63:0]          bits_i,
  output f5e_pkg::unpack_t     fields_o
);

  logic [62:0] mag;
  logic [62:0] mag_clamped;
  logic [10:0] exp_field;
  logic        pow2;
  logic [10:0] biased_wide;
  logic [7:0]  biased;

  always_comb begin
    mag = bits_i[62:0];
    if (mag > f5e_pkg::BigBits) begin
      mag_clamped = f5e_pkg::BigBits;
    end else if (mag < f5e_pkg::SmallBits) begin
      mag_clamped = f5e_pkg::SmallBits;
    end else begin
      mag_clamped = mag;
    end

    exp_field = mag_clamped[62:52];
    // An exact power of two below one is coded one exponent lower.
    pow2 = (exp_field < f5e_pkg::ExpBias) && (mag_clamped[51:0] == 52'd0);
    biased_wide = exp_field - f5e_pkg::ExpShift - {10'd0, pow2};
    biased = biased_wide[7:0];

    fields_o.zero = (mag == 63'd0);
    fields_o.neg  = bits_i[63];
    if (biased >= f5e_pkg::GroupTwo) begin
      fields_o.grp = 2'd2;
      fields_o.dg3 = 7'(biased - f5e_pkg::GroupTwo);
    end else if (biased >= f5e_pkg::Base1Wide) begin
      fields_o.grp = 2'd1;
      fields_o.dg3 = 7'(biased - f5e_pkg::Base1Wide);
    end else begin
      fields_o.grp = 2'd0;
      fields_o.dg3 = biased[6:0];
    end
    fields_o.frac = pow2 ? f5e_pkg::FracOne : {1'b0, mag_clamped[51:29]};
  end

endmodule

### design/f5e_radix.sv
// ----------------------------------------------------------------------------
// f5e_radix
// Pipelined split of the fraction into base-90 digits, one constant division
// per stage.
// ----------------------------------------------------------------------------
module f5e_radix (
  input  logic                 clk_i,
  input  logic                 advance_i,
  input  f5e_pkg::unpack_t     fields_i,
  output f5e_pkg::digits_t     digits_o
);

  typedef struct packed {
    logic        zero;
    logic        neg;
    logic [1:0]  grp;
    logic [6:0]  dg3;
    logic [3:0]  q4;
  } head_t;

  f5e_pkg::unpack_t fields_q;
  head_t            head_b_q, head_c_q, head_d_q;
  logic [19:0]      rest1_b_q, rest1_c_q;
  logic [6:0]       dg2_c_q, dg2_d_q;
  logic [12:0]      r2_d_q;
  f5e_pkg::digits_t digits_q;

  logic [3:0]  q4_d;
  logic [23:0] sub_d;
  logic [39:0] prod2;
  logic [12:0] r2_d;
  logic [25:0] prod1;

  // Top digit by threshold compare; its value never exceeds eleven.
  always_comb begin
    q4_d  = 4'd0;
    sub_d = 24'd0;
    for (int k = 1; k <= f5e_pkg::Base3Max; k++) begin
      if (fields_q.frac >= 24'(k * f5e_pkg::Base3)) begin
        q4_d  = 4'(k);
        sub_d = 24'(k * f5e_pkg::Base3);
      end
    end
  end

  assign prod2 = rest1_b_q * f5e_pkg::Recip2;
  assign r2_d  = 13'(rest1_c_q - 20'(dg2_c_q) * 20'(f5e_pkg::Base2));
  assign prod1 = r2_d_q * f5e_pkg::Recip1;

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      fields_q <= fields_i;

      head_b_q  <= '{zero: fields_q.zero, neg: fields_q.neg, grp: fields_q.grp,
                     dg3: fields_q.dg3, q4: q4_d};
      rest1_b_q <= 20'(fields_q.frac - sub_d);

      head_c_q  <= head_b_q;
      rest1_c_q <= rest1_b_q;
      dg2_c_q   <= prod2[38:32];

      head_d_q <= head_c_q;
      dg2_d_q  <= dg2_c_q;
      r2_d_q   <= r2_d;

      digits_q.zero <= head_d_q.zero;
      digits_q.neg  <= head_d_q.neg;
      digits_q.grp  <= head_d_q.grp;
      digits_q.dg3  <= head_d_q.dg3;
      digits_q.q4   <= head_d_q.q4;
      digits_q.dg2  <= dg2_d_q;
      digits_q.dg1  <= prod1[25:19];
      digits_q.r2   <= r2_d_q;
    end
  end

  assign digits_o = digits_q;

endmodule

### design/f5e_charmap.sv
// ----------------------------------------------------------------------------
// f5e_charmap
// Forms the last digit and the combined top digit, then maps all five digits
// to printable characters.
// ----------------------------------------------------------------------------
module f5e_charmap (
  input  f5e_pkg::digits_t     digits_i,
  output f5e_pkg::chars_t      chars_o
);

  logic [12:0] low_wide;
  logic [6:0]  dg0;
  logic [6:0]  dg4;

  always_comb begin
    low_wide = digits_i.r2 - 13'(digits_i.dg1 * f5e_pkg::Base1);
    dg0 = low_wide[6:0];
    dg4 = {3'd0, digits_i.q4} + 7'(digits_i.grp * f5e_pkg::GroupStep)
        + (digits_i.neg ? f5e_pkg::NegOffset : 7'd0);

    if (digits_i.zero) begin
      chars_o.c0 = f5e_pkg::to_char(7'd0);
      chars_o.c1 = f5e_pkg::to_char(7'd0);
      chars_o.c2 = f5e_pkg::to_char(7'd0);
      chars_o.c3 = f5e_pkg::to_char(7'd0);
      chars_o.c4 = f5e_pkg::to_char(f5e_pkg::ZeroMark);
    end else begin
      chars_o.c0 = f5e_pkg::to_char(dg0);
      chars_o.c1 = f5e_pkg::to_char(digits_i.dg1);
      chars_o.c2 = f5e_pkg::to_char(digits_i.dg2);
      chars_o.c3 = f5e_pkg::to_char(digits_i.dg3);
      chars_o.c4 = f5e_pkg::to_char(dg4);
    end
  end

endmodule

### design/float_to_five_char_encoder_top.sv
// ----------------------------------------------------------------------------
// float_to_five_char_encoder_top
// Encodes a binary64 bit pattern as five printable characters.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes through seven register stages (input, five
// digit stages, output) before its result is valid.
// Throughput: one item per cycle; the whole pipeline holds while a result
// waits at a stalled output, so the receiver sets the pace.
// Reset clears the stage valid flags only; no clearing pass is needed.
module float_to_five_char_encoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] value_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  char_zero_o,
  output logic [6:0]  char_one_o,
  output logic [6:0]  char_two_o,
  output logic [6:0]  char_three_o,
  output logic [6:0]  char_four_o
);

  logic [f5e_pkg::PipeStages-1:0] vld_q;
  logic                           advance;
  logic [63:0]                    bits_q;
  f5e_pkg::unpack_t               fields;
  f5e_pkg::digits_t               digits;
  f5e_pkg::chars_t                chars_d, chars_q;

  assign advance    = !(vld_q[f5e_pkg::PipeStages-1] && out_stall_i);
  assign in_stall_o = !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[f5e_pkg::PipeStages-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      bits_q  <= value_bits_i;
      chars_q <= chars_d;
    end
  end

  f5e_unpack u_unpack (
    .bits_i   (bits_q),
    .fields_o (fields)
  );

  f5e_radix u_radix (
    .clk_i     (clk_i),
    .advance_i (advance),
    .fields_i  (fields),
    .digits_o  (digits)
  );

  f5e_charmap u_charmap (
    .digits_i (digits),
    .chars_o  (chars_d)
  );

  assign out_valid_o  = vld_q[f5e_pkg::PipeStages-1];
  assign char_zero_o  = chars_q.c0;
  assign char_one_o   = chars_q.c1;
  assign char_two_o   = chars_q.c2;
  assign char_three_o = chars_q.c3;
  assign char_four_o  = chars_q.c4;

  // The zero marker only ever appears with all other digits at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && char_four_o == 7'd114) |->
      (char_zero_o == 7'd33 && char_one_o == 7'd33 &&
       char_two_o == 7'd33 && char_three_o == 7'd33))
    else $error("zero marker with nonzero digits");

  // The excluded codes never leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (char_zero_o != f5e_pkg::SkipLow && char_zero_o != f5e_pkg::SkipHigh &&
       char_one_o != f5e_pkg::SkipLow && char_one_o != f5e_pkg::SkipHigh &&
       char_two_o != f5e_pkg::SkipLow && char_two_o != f5e_pkg::SkipHigh &&
       char_three_o != f5e_pkg::SkipLow && char_three_o != f5e_pkg::SkipHigh &&
       char_four_o != f5e_pkg::SkipLow && char_four_o != f5e_pkg::SkipHigh))
    else $error("excluded character code on output");

  // A stalled output freezes every stage, so no item is lost in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(vld_q))
    else $error("pipeline moved while output stalled");

  // Every character lies in the printable range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_zero_o >= 7'd33 && char_one_o >= 7'd33 &&
                     char_two_o >= 7'd33 && char_three_o >= 7'd33 &&
                     char_four_o >= 7'd33 && char_four_o <= 7'd124))
    else $error("character out of range");

endmodule

### tb/sv/f5e_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f5e_checker
// Watches both channels of the five-character float encoder, works out the
// characters each accepted item should give and compares them, in order, with
// the results the block hands over.
// ----------------------------------------------------------------------------
module f5e_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [63:0] value_bits_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [6:0]  char_zero_i,
  input  logic [6:0]  char_one_i,
  input  logic [6:0]  char_two_i,
  input  logic [6:0]  char_three_i,
  input  logic [6:0]  char_four_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          result_count_o
);

  localparam int unsigned Radix1    = 90;
  localparam int unsigned Radix2    = 8100;
  localparam int unsigned Radix3    = 729000;
  localparam int          ExpOffset = 129;

  typedef logic [6:0] char_t;

  typedef struct packed {
    char_t c0;
    char_t c1;
    char_t c2;
    char_t c3;
    char_t c4;
  } enc_chars_t;

  enc_chars_t expected_chars_q[$];
  int         mismatches = 0;
  int         pending = 0;
  int         results_seen = 0;

  assign fail_count_o   = mismatches;
  assign pending_o      = pending;
  assign result_count_o = results_seen;

  // Digits are offset into printable ASCII, stepping over the caret and the
  // opening brace.
  function automatic char_t digit_to_char(input int unsigned d);
    int unsigned c;
    c = d + 32'(f5e_pkg::CharBase);
    if (c >= 32'(f5e_pkg::SkipLow)) c = c + 1;
    if (c >= 32'(f5e_pkg::SkipHigh)) c = c + 1;
    return char_t'(c);
  endfunction

  function automatic enc_chars_t encode_float(input logic [63:0] value);
    logic [62:0] mag;
    int          e;
    int unsigned frac;
    int unsigned biased;
    int unsigned grp;
    int unsigned rest;
    int unsigned dg[5];
    enc_chars_t  res;
    mag = value[62:0];
    if (mag == '0) begin
      dg[0] = 0;
      dg[1] = 0;
      dg[2] = 0;
      dg[3] = 0;
      dg[4] = 32'(f5e_pkg::ZeroMark);
    end else begin
      // Infinity and NaN sit above the upper limit as integers, so they clamp
      // with everything else that is too large.
      if (mag > f5e_pkg::BigBits) mag = f5e_pkg::BigBits;
      if (mag < f5e_pkg::SmallBits) mag = f5e_pkg::SmallBits;
      e    = int'(mag[62:52]) - int'(f5e_pkg::ExpBias);
      frac = 32'(mag[51:29]);
      if (e < 0 && mag[51:0] == '0) begin
        e    = e - 1;
        frac = 32'(f5e_pkg::FracOne);
      end
      biased = 32'(e + ExpOffset);
      grp    = biased / Radix1;
      dg[3]  = biased % Radix1;
      dg[4]  = frac / Radix3;
      rest   = frac % Radix3;
      dg[2]  = rest / Radix2;
      rest   = rest % Radix2;
      dg[1]  = rest / Radix1;
      dg[0]  = rest % Radix1;
      dg[4]  = dg[4] + grp * 32'(f5e_pkg::GroupStep);
      if (value[63]) dg[4] = dg[4] + 32'(f5e_pkg::NegOffset);
    end
    res.c0 = digit_to_char(dg[0]);
    res.c1 = digit_to_char(dg[1]);
    res.c2 = digit_to_char(dg[2]);
    res.c3 = digit_to_char(dg[3]);
    res.c4 = digit_to_char(dg[4]);
    return res;
  endfunction

  task automatic check_char(input string field, input char_t want, input char_t got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    enc_chars_t want;
    if (!rst_ni) begin
      expected_chars_q.delete();
      pending = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (expected_chars_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with no item waiting for it", $time);
        end else begin
          want = expected_chars_q.pop_front();
          check_char("char_zero", want.c0, char_zero_i);
          check_char("char_one", want.c1, char_one_i);
          check_char("char_two", want.c2, char_two_i);
          check_char("char_three", want.c3, char_three_i);
          check_char("char_four", want.c4, char_four_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_chars_q.insert(expected_chars_q.size(), encode_float(value_bits_i));
      end
      pending = expected_chars_q.size();
    end
  end

endmodule

### tb/sv/float_to_five_char_encoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_to_five_char_encoder_top_tb
// Feeds the encoder directed and random binary64 patterns with random gaps on
// both sides, one long output hold-off and stretches at full rate, and leaves
// the checking of the characters to the checker beside the block.
// ----------------------------------------------------------------------------
module float_to_five_char_encoder_top_tb;

  localparam int MaxCycles     = 400000;
  localparam int PhaseCount    = 5;
  localparam int PhaseItems    = 325;
  localparam int HoldOffCycles = 80;
  localparam int BurstItems    = 60;
  localparam int DrainCycles   = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] value_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  char_zero;
  logic [6:0]  char_one;
  logic [6:0]  char_two;
  logic [6:0]  char_three;
  logic [6:0]  char_four;

  int fail_count;
  int pending;
  int result_count;
  int cycle_count = 0;
  int items_sent = 0;
  bit no_idle = 1'b0;
  bit hold_off_req = 1'b0;
  int burst_left = 0;

  float_to_five_char_encoder_top u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .value_bits_i (value_bits),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .char_zero_o  (char_zero),
    .char_one_o   (char_one),
    .char_two_o   (char_two),
    .char_three_o (char_three),
    .char_four_o  (char_four)
  );

  f5e_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .value_bits_i   (value_bits),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .char_zero_i    (char_zero),
    .char_one_i     (char_one),
    .char_two_i     (char_two),
    .char_three_i   (char_three),
    .char_four_i    (char_four),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .result_count_o (result_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("float_to_five_char_encoder_top_tb failed");
      $finish;
    end
  end

  task automatic send_value(input logic [63:0] v);
    int gap;
    gap = (no_idle || burst_left > 0) ? 0 : $urandom_range(0, 10);
    if (burst_left > 0) burst_left--;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    value_bits <= v;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Most random items land inside the clamp limits, since that is where the
  // digit arithmetic does its work; the rest probe the limits and the codes
  // for zero, infinity, NaN and subnormals.
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9)) inside
      0: ;
      [1:4]: v[62:52] = 11'($urandom_range(929, 1116));
      5: begin
        v[62:52] = 11'($urandom_range(900, 1130));
        v[51:0]  = '0;
      end
      6: v[62:0] = ($urandom_range(0, 1) ? f5e_pkg::BigBits : f5e_pkg::SmallBits)
                   + 63'($urandom_range(0, 8)) - 63'd4;
      7: begin
        v[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
        if ($urandom_range(0, 1)) v[51:0] = '0;
      end
      8: v[62:52] = $urandom_range(0, 1) ? 11'($urandom_range(1117, 2046))
                                         : 11'($urandom_range(1, 928));
      default: begin
        v[62:52] = 11'($urandom_range(929, 1116));
        v[51:29] = $urandom_range(0, 1) ? '1 : '0;
      end
    endcase
    return v;
  endfunction

  // Receiver: a random hold before each result, none in the full-rate phase,
  // and one long hold-off when the sender asks for it.
  initial begin : receiver
    int hold;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        repeat (HoldOffCycles) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
      hold = no_idle ? 0 : $urandom_range(0, 10);
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    logic [63:0] directed_values[$];
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_values = '{
      64'h0000000000000000, 64'h8000000000000000,  // both zeros
      64'h7FF0000000000000, 64'hFFF0000000000000,  // infinities
      64'h7FF8000000000000, 64'hFFF0000000000001,  // NaNs
      64'h3FF0000000000000, 64'hBFF0000000000000,  // one, minus one
      64'h3FE0000000000000, 64'hBFD0000000000000,  // powers of two below one
      64'h4000000000000000, 64'h3FFFFFFFFFFFFFFF,  // two, largest fraction
      64'h7FEFFFFFFFFFFFFF, 64'h0000000000000001,  // largest, smallest subnormal
      64'h000FFFFFFFFFFFFF, 64'h0010000000000000,  // subnormal edge, smallest normal
      64'h45C027E72F1F1281, 64'h45C027E72F1F1282,  // upper limit and just above
      64'hBA1FB0F6BE506019, 64'h3A1FB0F6BE506018,  // lower limit and just below
      64'h3A20000000000000, 64'hC5C0000000000000,  // extreme exponents inside limits
      64'hFFFFFFFFFFFFFFFF, 64'h5555555555555555
    };
    foreach (directed_values[i]) send_value(directed_values[i]);

    for (int phase = 0; phase < PhaseCount; phase++) begin
      no_idle = (phase == 2);
      if (phase == 3) begin
        // Fill the pipeline against a held output so that the input stalls.
        hold_off_req = 1'b1;
        burst_left   = BurstItems;
      end
      for (int n = 0; n < PhaseItems; n++) send_value(random_value());
    end
    no_idle = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d items and checked %0d results across zeros, infinities, NaNs,",
             items_sent, result_count);
    $display("subnormals, both clamp limits, powers of two and a long output hold-off.");
    if (fail_count == 0) begin
      $display("float_to_five_char_encoder_top_tb passed");
    end else begin
      $display("float_to_five_char_encoder_top_tb failed");
    end
    $finish;
  end

endmodule
